// ===== rtl/assert_macros.svh =====
// assertion macros for the pulse channel block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PCA_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PCA_ASSERT(lbl, prop, msg)
`define PCA_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ===== rtl/pca_pkg.sv =====
// shared types, codes and the duty table of the pulse channel
package pca_pkg;
  localparam int unsigned CyclesPerSample = 87;
  localparam int unsigned FramePeriod     = 8192;
  localparam int unsigned MaxResults      = 16;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_ADV   = 2'd2;

  localparam logic [15:0] ADDR_DUTY_LEN = 16'hFF16;
  localparam logic [15:0] ADDR_VOL_ENV  = 16'hFF17;
  localparam logic [15:0] ADDR_PER_LO   = 16'hFF18;
  localparam logic [15:0] ADDR_PER_HI   = 16'hFF19;
  localparam logic [15:0] ADDR_POWER    = 16'hFF26;

  // controller to datapath
  typedef struct packed {
    logic do_write;
    logic do_read;
    logic do_adv;
    logic frame_step;
    logic period_step;
    logic period_done;
    logic emit;
  } pca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_pending;
    logic period_pending;
    logic sample_pending;
  } pca_sts_t;

  // standard duty patterns, position 0 is the leftmost bit
  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    logic [7:0] pat;
    case (duty)
      2'd0:    pat = 8'b00000001;
      2'd1:    pat = 8'b10000001;
      2'd2:    pat = 8'b10000111;
      default: pat = 8'b01111110;
    endcase
    return pat[3'd7 - pos];
  endfunction
endpackage

// ===== rtl/pca_ctrl.sv =====
// sequencer for the pulse channel: input accept, frame, period and sample phases
module pca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pca_pkg::pca_sts_t sts_i,
  output pca_pkg::pca_cmd_t cmd_o
);
  import pca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FRAME  = 4'b0010,
    S_PERIOD = 4'b0100,
    S_SAMPLE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free, acc;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (func_i)
            FUNC_WRITE: cmd_o.do_write = 1'b1;
            FUNC_READ:  cmd_o.do_read  = 1'b1;
            FUNC_ADV: begin
              cmd_o.do_adv = 1'b1;
              state_d      = S_FRAME;
            end
            default: ;
          endcase
        end
      end
      S_FRAME: begin
        if (sts_i.frame_pending) cmd_o.frame_step = 1'b1;
        else state_d = S_PERIOD;
      end
      S_PERIOD: begin
        if (sts_i.period_pending) cmd_o.period_step = 1'b1;
        else begin
          cmd_o.period_done = 1'b1;
          state_d           = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        if (!sts_i.sample_pending) state_d = S_IDLE;
        else if (slot_free) cmd_o.emit = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.do_read || cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

// ===== rtl/pca_dp.sv =====
// channel registers, timers and output beat register of the pulse channel
module pca_dp #(
  parameter int unsigned SAMPLE_PERIOD = pca_pkg::CyclesPerSample,
  parameter int unsigned FRAME_PERIOD  = pca_pkg::FramePeriod
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pca_pkg::pca_cmd_t cmd_i,
  output pca_pkg::pca_sts_t sts_o,
  input  logic [15:0]       reg_address_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        cycle_count_i,
  output logic              kind_o,
  output logic [3:0]        sample_level_o,
  output logic [7:0]        read_data_o,
  output logic              last_o
);
  import pca_pkg::*;

  localparam int unsigned FCW = $clog2(FRAME_PERIOD + 256);
  localparam int unsigned SCW = $clog2(SAMPLE_PERIOD + 256);
  localparam int unsigned NW  = $clog2(MaxResults + 1);
  localparam logic [FCW-1:0] FP  = FCW'(FRAME_PERIOD);
  localparam logic [SCW-1:0] CPS = SCW'(SAMPLE_PERIOD);

  logic           power_q, power_d;
  logic [FCW-1:0] fcnt_q, fcnt_d;
  logic [2:0]     fstep_q, fstep_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic [7:0]     dl_q, dl_d, ve_q, ve_d, plo_q, plo_d, phi_q, phi_d;
  logic           en_q, en_d, len_en_q, len_en_d;
  logic [6:0]     len_q, len_d;
  logic [3:0]     vol_q, vol_d;
  logic           env_up_q, env_up_d;
  logic [2:0]     env_per_q, env_per_d, env_cd_q, env_cd_d;
  logic [2:0]     duty_q, duty_d;
  logic [14:0]    pcd_q, pcd_d;
  logic [16:0]    t_q, t_d;
  logic [NW-1:0]  n_q, n_d;
  logic           kind_q, last_q;
  logic [3:0]     lvl_q;
  logic [7:0]     rd_q;

  logic [13:0]    reload, reload_trig;
  logic [2:0]     fstep_nx, cd_dec;
  logic [SCW-1:0] srem;
  logic [3:0]     level;

  function automatic logic [13:0] reload_of(input logic [2:0] hi, input logic [7:0] lo);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, hi, lo};
    return {diff, 2'b00};
  endfunction

  assign reload      = reload_of(phi_q[2:0], plo_q);
  assign reload_trig = reload_of(write_data_i[2:0], plo_q);
  assign fstep_nx    = fstep_q + 3'd1;
  assign cd_dec      = env_cd_q - 3'd1;
  assign srem        = scnt_q - CPS;
  assign level       = (en_q && duty_bit(dl_q[7:6], duty_q)) ? vol_q : 4'd0;

  assign sts_o.frame_pending  = fcnt_q >= FP;
  assign sts_o.period_pending = en_q && (t_q[16] || (t_q == 17'd0));
  assign sts_o.sample_pending = (scnt_q >= CPS) && (n_q < NW'(MaxResults));

  // channel state update
  always_comb begin
    power_d = power_q; fcnt_d = fcnt_q; fstep_d = fstep_q; scnt_d = scnt_q;
    dl_d = dl_q; ve_d = ve_q; plo_d = plo_q; phi_d = phi_q;
    en_d = en_q; len_en_d = len_en_q; len_d = len_q; vol_d = vol_q;
    env_up_d = env_up_q; env_per_d = env_per_q; env_cd_d = env_cd_q;
    duty_d = duty_q; pcd_d = pcd_q; t_d = t_q; n_d = n_q;

    // register writes and trigger
    if (cmd_i.do_write) begin
      unique case (reg_address_i)
        ADDR_DUTY_LEN: dl_d = write_data_i;
        ADDR_VOL_ENV: begin
          ve_d      = write_data_i;
          vol_d     = write_data_i[7:4];
          env_up_d  = write_data_i[3];
          env_per_d = write_data_i[2:0];
        end
        ADDR_PER_LO: plo_d = write_data_i;
        ADDR_PER_HI: begin
          phi_d    = write_data_i;
          len_en_d = write_data_i[6];
          if (write_data_i[7]) begin
            en_d      = 1'b1;
            len_d     = 7'd64 - {1'b0, dl_q[5:0]};
            env_up_d  = ve_q[3];
            env_per_d = ve_q[2:0];
            env_cd_d  = ve_q[2:0];
            vol_d     = ve_q[7:4];
            duty_d    = 3'd0;
            pcd_d     = {1'b0, reload_trig};
          end
        end
        ADDR_POWER: begin
          if (write_data_i[7]) power_d = 1'b1;
          else begin
            power_d = 1'b0;
            dl_d = '0; ve_d = '0; plo_d = '0; phi_d = '0;
          end
        end
        default: ;
      endcase
    end

    // advance entry: add cycles to both counters, start period countdown
    if (cmd_i.do_adv) begin
      fcnt_d = fcnt_q + FCW'(cycle_count_i);
      scnt_d = scnt_q + SCW'(cycle_count_i);
      t_d    = {2'b00, pcd_q} - {9'd0, cycle_count_i};
      n_d    = '0;
    end

    // one frame sequencer step
    if (cmd_i.frame_step) begin
      fcnt_d  = fcnt_q - FP;
      fstep_d = fstep_nx;
      if (!fstep_nx[0] && len_en_q && (len_q != 7'd0)) begin
        len_d = len_q - 7'd1;
        if (len_q == 7'd1) en_d = 1'b0;
      end
      if ((fstep_nx == 3'd7) && en_q && (env_per_q != 3'd0)) begin
        env_cd_d = cd_dec;
        if (cd_dec == 3'd0) begin
          env_cd_d = env_per_q;
          if (env_up_q) begin
            if (vol_q != 4'd15) vol_d = vol_q + 4'd1;
          end else if (vol_q != 4'd0) begin
            vol_d = vol_q - 4'd1;
          end
        end
      end
    end

    // one period reload and duty step
    if (cmd_i.period_step) begin
      t_d    = t_q + {3'd0, reload};
      duty_d = duty_q + 3'd1;
    end
    if (cmd_i.period_done && en_q) pcd_d = t_q[14:0];

    // one sample
    if (cmd_i.emit) begin
      scnt_d = srem;
      n_d    = n_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= 1'b1; fcnt_q <= '0; fstep_q <= '0; scnt_q <= '0;
      dl_q <= '0; ve_q <= '0; plo_q <= '0; phi_q <= '0;
      en_q <= 1'b0; len_en_q <= 1'b0; len_q <= '0; vol_q <= '0;
      env_up_q <= 1'b0; env_per_q <= '0; env_cd_q <= '0;
      duty_q <= '0; pcd_q <= '0; t_q <= '0; n_q <= '0;
    end else begin
      power_q <= power_d; fcnt_q <= fcnt_d; fstep_q <= fstep_d; scnt_q <= scnt_d;
      dl_q <= dl_d; ve_q <= ve_d; plo_q <= plo_d; phi_q <= phi_d;
      en_q <= en_d; len_en_q <= len_en_d; len_q <= len_d; vol_q <= vol_d;
      env_up_q <= env_up_d; env_per_q <= env_per_d; env_cd_q <= env_cd_d;
      duty_q <= duty_d; pcd_q <= pcd_d; t_q <= t_d; n_q <= n_d;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_read) begin
      kind_q <= 1'b1;
      lvl_q  <= 4'd0;
      rd_q   <= {power_q, 3'b111, 2'b00, en_q, 1'b0};
      last_q <= 1'b1;
    end else if (cmd_i.emit) begin
      kind_q <= 1'b0;
      lvl_q  <= level;
      rd_q   <= 8'd0;
      last_q <= (srem < CPS) || (n_q == NW'(MaxResults - 1));
    end
  end

  assign kind_o         = kind_q;
  assign sample_level_o = lvl_q;
  assign read_data_o    = rd_q;
  assign last_o         = last_q;
endmodule

// ===== rtl/pulse_channel_apu.sv =====
// Pulse channel sound unit: one item per beat; writes and reads are handled without leaving idle.
// An advance runs the frame, period and sample phases in turn: F frame steps (<= 1),
// P period reloads (<= 64), S samples (<= 3), one per cycle, samples only while the output slot is free.
// A status read beat appears the cycle after accept; next input accepted once idle and the output slot is free.
// Reset: asynchronous active low; power on, all channel state and counters cleared.
module pulse_channel_apu #(
  parameter int unsigned SAMPLE_PERIOD = pca_pkg::CyclesPerSample,
  parameter int unsigned FRAME_PERIOD  = pca_pkg::FramePeriod
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] reg_address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  cycle_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [3:0]  sample_level_o,
  output logic [7:0]  read_data_o,
  output logic        last_o
);
  import pca_pkg::*;
  `include "assert_macros.svh"

  pca_cmd_t cmd;
  pca_sts_t sts;

  pca_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  pca_dp #(
    .SAMPLE_PERIOD(SAMPLE_PERIOD),
    .FRAME_PERIOD(FRAME_PERIOD)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .reg_address_i, .write_data_i, .cycle_count_i,
    .kind_o, .sample_level_o, .read_data_o, .last_o
  );

  `PCA_ASSERT(a_emit_busy, cmd.emit |-> !in_ready_o, "sample emitted while accepting input")
  `PCA_ASSERT(a_adv_busy, cmd.do_adv |=> !in_ready_o, "input accepted during an advance")
  `PCA_ASSERT(a_read_last, (out_valid_o && kind_o) |-> last_o, "status beat not marked last")
  `PCA_ASSERT(a_ready_slot, in_ready_o |-> (!out_valid_o || out_ready_i),
              "input accepted with output slot full")
endmodule

// ===== dv/pulse_channel_apu_test.sv =====
// testbench for the pulse channel sound unit: queued stimulus, bursty driver, stalling receiver, monitor
module pulse_channel_apu_test;
  import pca_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } apu_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] level;
    logic [7:0] status;
    logic       last;
  } apu_beat_t;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_WRITE;
  logic [15:0] reg_address_i = '0;
  logic [7:0]  write_data_i = '0;
  logic [7:0]  cycle_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [3:0]  sample_level_o;
  logic [7:0]  read_data_o;
  logic        last_o;

  pulse_channel_apu i_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic        pwr;
  logic [12:0] frame_cnt;
  logic [2:0]  frame_step;
  logic [10:0] sample_cnt;
  logic [7:0]  nr_duty, nr_env, nr_lo, nr_hi;
  logic        chan_on, len_en;
  logic [6:0]  len_left;
  logic [3:0]  vol;
  logic        env_up;
  logic [2:0]  env_per, env_cnt;
  logic [2:0]  duty_pos;
  logic [14:0] per_cnt;

  apu_item_t pending_items[$];
  apu_beat_t expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned items_sent = 0;
  bit          stim_done = 1'b0;
  bit          hold_off = 1'b0;

  function automatic logic [14:0] period_reload();
    return 15'((2048 - {nr_hi[2:0], nr_lo}) * 4);
  endfunction

  function automatic logic duty_high(logic [1:0] d, logic [2:0] pos);
    logic [7:0] pat;
    case (d)
      2'd0:    pat = 8'b00000001;
      2'd1:    pat = 8'b10000001;
      2'd2:    pat = 8'b10000111;
      default: pat = 8'b01111110;
    endcase
    return pat[7 - pos];
  endfunction

  task automatic predictor_reset();
    pwr = 1'b1; frame_cnt = '0; frame_step = '0; sample_cnt = '0;
    nr_duty = '0; nr_env = '0; nr_lo = '0; nr_hi = '0;
    chan_on = 1'b0; len_en = 1'b0; len_left = '0; vol = '0; env_up = 1'b0;
    env_per = '0; env_cnt = '0; duty_pos = '0; per_cnt = '0;
  endtask

  // apply one item and queue the beats it causes
  task automatic predict_item(apu_item_t it);
    int t;
    int fc;
    int sc;
    int n;
    apu_beat_t b;
    if (it.func == FUNC_WRITE) begin
      case (it.addr)
        ADDR_DUTY_LEN: nr_duty = it.data;
        ADDR_VOL_ENV: begin
          nr_env = it.data; vol = it.data[7:4]; env_up = it.data[3]; env_per = it.data[2:0];
        end
        ADDR_PER_LO: nr_lo = it.data;
        ADDR_PER_HI: begin
          nr_hi = it.data;
          len_en = it.data[6];
          if (it.data[7]) begin
            chan_on = 1'b1;
            len_left = 7'(64 - nr_duty[5:0]);
            env_up = nr_env[3]; env_per = nr_env[2:0]; env_cnt = nr_env[2:0];
            vol = nr_env[7:4]; duty_pos = '0; per_cnt = period_reload();
          end
        end
        ADDR_POWER: begin
          pwr = it.data[7];
          if (!it.data[7]) begin
            nr_duty = '0; nr_env = '0; nr_lo = '0; nr_hi = '0;
          end
        end
        default: ;
      endcase
    end else if (it.func == FUNC_READ) begin
      b.kind = 1'b1; b.level = '0; b.last = 1'b1;
      b.status = {pwr, 3'b111, 2'b00, chan_on, 1'b0};
      expected_beats.push_back(b);
    end else if (it.func == FUNC_ADV) begin
      // frame sequencer
      fc = frame_cnt + it.cycles;
      while (fc >= FramePeriod) begin
        fc -= FramePeriod;
        frame_step++;
        if (!frame_step[0] && len_en && len_left > 0) begin
          len_left--;
          if (len_left == 0) chan_on = 1'b0;
        end
        if (frame_step == 3'd7 && chan_on && env_per != 0) begin
          env_cnt--;
          if (env_cnt == 0) begin
            env_cnt = env_per;
            if (env_up) begin
              if (vol < 15) vol++;
            end else if (vol > 0) begin
              vol--;
            end
          end
        end
      end
      frame_cnt = 13'(fc);
      // period timer
      if (chan_on) begin
        t = int'(per_cnt) - int'(it.cycles);
        while (t <= 0) begin
          t += period_reload();
          duty_pos++;
        end
        per_cnt = 15'(t);
      end
      // samples
      sc = sample_cnt + it.cycles;
      n = 0;
      while (sc >= CyclesPerSample && n < MaxResults) begin
        sc -= CyclesPerSample;
        b.kind = 1'b0; b.status = '0; b.last = 1'b0;
        b.level = (chan_on && duty_high(nr_duty[7:6], duty_pos)) ? vol : 4'd0;
        expected_beats.push_back(b);
        n++;
      end
      sample_cnt = 11'(sc);
      if (n > 0) expected_beats[$].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h", beats_seen, what, got, want);
    mismatches++;
  endtask

  // driver: bursts with random gaps
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i) begin
        // still waiting for accept; payload held
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        func_i <= pending_items[0].func;
        reg_address_i <= pending_items[0].addr;
        write_data_i <= pending_items[0].data;
        cycle_count_i <= pending_items[0].cycles;
        in_valid_i <= 1'b1;
        void'(pending_items.pop_front());
      end
    end
  end

  // accept, predict and pick the next gap
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_item('{func_i, reg_address_i, write_data_i, cycle_count_i});
      items_sent++;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left <= $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      end else begin
        burst_left--;
      end
      in_valid_i <= 1'b0;
    end
  end

  // receiver stall pattern
  int unsigned stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) out_ready_i <= 1'b0;
    else if (stall_phase[7]) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    apu_beat_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", kind_o, 0);
      end else begin
        want = expected_beats.pop_front();
        if (kind_o != want.kind) report_mismatch("kind", kind_o, want.kind);
        if (sample_level_o != want.level) report_mismatch("level", sample_level_o, want.level);
        if (read_data_o != want.status) report_mismatch("status", read_data_o, want.status);
        if (last_o != want.last) report_mismatch("last", last_o, want.last);
      end
      beats_seen++;
    end
  end

  // watchdog on cycles with no accepted input item or output beat
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic apu_item_t mk(logic [1:0] f, logic [15:0] a, logic [7:0] d,
                                   logic [7:0] c);
    return '{f, a, d, c};
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 6))
      0: return ADDR_DUTY_LEN;
      1: return ADDR_VOL_ENV;
      2: return ADDR_PER_LO;
      3: return ADDR_PER_HI;
      4: return ADDR_POWER;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int k;
    predictor_reset();
    // directed part
    pending_items.push_back(mk(FUNC_READ, 16'h0000, 8'h00, 8'h00));
    pending_items.push_back(mk(FUNC_ADV, 16'hFFFF, 8'hFF, 8'hFF));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_DUTY_LEN, 8'hBF, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_VOL_ENV, 8'hF1, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_LO, 8'hFF, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_HI, 8'hC7, 8'h00));
    pending_items.push_back(mk(FUNC_READ, 16'h0000, 8'h00, 8'h00));
    for (k = 0; k < 6; k++) pending_items.push_back(mk(FUNC_ADV, 16'h0, 8'h0, 8'hFF));
    pending_items.push_back(mk(FUNC_ADV, 16'h0, 8'h0, 8'h00));
    pending_items.push_back(mk(2'd3, ADDR_POWER, 8'h00, 8'hFF));
    pending_items.push_back(mk(FUNC_WRITE, 16'h1234, 8'h55, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_VOL_ENV, 8'h09, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_LO, 8'h00, 8'h00));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_HI, 8'h80, 8'h00));
    pending_items.push_back(mk(FUNC_ADV, 16'h0, 8'h0, 8'h80));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_POWER, 8'h00, 8'h00));
    pending_items.push_back(mk(FUNC_READ, 16'h0, 8'h0, 8'h0));
    pending_items.push_back(mk(FUNC_WRITE, ADDR_POWER, 8'h80, 8'h00));
    pending_items.push_back(mk(FUNC_READ, 16'h0, 8'h0, 8'h0));
    // random part: advances, writes, reads, invalid functions and channel setup sequences
    for (k = 0; k < 75; k++) begin
      case ($urandom_range(0, 9))
        0, 1: pending_items.push_back(mk(FUNC_WRITE, pick_addr(), 8'($urandom),
                                         8'($urandom)));
        2: begin
          pending_items.push_back(mk(FUNC_WRITE, ADDR_DUTY_LEN, 8'($urandom), 8'h0));
          pending_items.push_back(mk(FUNC_WRITE, ADDR_VOL_ENV, 8'($urandom), 8'h0));
          pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_LO, 8'($urandom), 8'h0));
          pending_items.push_back(mk(FUNC_WRITE, ADDR_PER_HI,
                                     8'($urandom) | 8'h80, 8'h0));
        end
        3: pending_items.push_back(mk(FUNC_READ, 16'($urandom), 8'($urandom),
                                      8'($urandom)));
        4: pending_items.push_back(mk(2'd3, 16'($urandom), 8'($urandom), 8'($urandom)));
        default: pending_items.push_back(mk(FUNC_ADV, 16'($urandom), 8'($urandom),
                                            8'($urandom)));
      endcase
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // long receiver hold-off while the sender keeps offering
    repeat (100) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_beats.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("run covered %0d items and %0d output beats", items_sent, beats_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
